FILE: sv/lsf_pkg.sv
package lsf_pkg;

  // input action codes
  typedef enum logic [1:0] {
    ACT_BYTE     = 2'd0,
    ACT_EOL      = 2'd1,
    ACT_NEW_FILE = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_t;

  // number modes
  localparam logic [1:0] NUM_NONE     = 2'd0;
  localparam logic [1:0] NUM_ABSOLUTE = 2'd1;
  localparam logic [1:0] NUM_OFFSET   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_PAT_LOW   = 3'd0;
  localparam logic [2:0] REG_PAT_HIGH  = 3'd1;
  localparam logic [2:0] REG_PAT_LEN   = 3'd2;
  localparam logic [2:0] REG_CASE      = 3'd3;
  localparam logic [2:0] REG_INVERT    = 3'd4;
  localparam logic [2:0] REG_NONBLANK  = 3'd5;
  localparam logic [2:0] REG_WINDOW    = 3'd6;
  localparam logic [2:0] REG_NUM_MODE  = 3'd7;

  localparam int LEN_W     = 5;
  localparam int WIN_W     = 16;
  localparam int CNT_W     = 32;
  localparam int BIL_W     = 16;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // one queued line record
  typedef struct packed {
    logic restart;   // start of new file
    logic sel;       // selection before the window is applied
  } entry_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic exact_case);
    logic [7:0] r;
    r = c;
    if (!exact_case && c >= CHR_UP_A && c <= CHR_UP_Z) r = c | CASE_BIT;
    return r;
  endfunction

  function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int i);
    logic [7:0] r;
    r = 8'h00;
    if (i < 8) r = lo[8*i +: 8];
    else if (i < 16) r = hi[8*(i-8) +: 8];
    return r;
  endfunction

endpackage

FILE: sv/line_substring_filter.sv
// channel  | direction | tdata                                  | tuser
// in_      | slave     | [7:0] byte_value                       | [1:0] action
// out_     | master    | [31:0] line_number, [63:32] shown_num  | [0] selected
// cfg_     | write     | cfg_wdata[63:0], cfg_index[2:0]        | -
//
// one transaction per cycle on the input; each byte is matched in the cycle it arrives
// against the byte history with one compare row per pattern length
// an end of line passes through the line queue and then through the registered line counter stage
// the front stalls only when the four-entry line queue is full; the back stalls on out_tready
// rst_n is synchronous, active low; config registers reset to zero, number_mode to absolute
module line_substring_filter #(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_LIMIT  = 65530
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] line_number, [63:32] shown_number
  output logic        out_tuser,  // [0] selected
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // configuration registers
  logic [63:0]                       pat_lo_r;
  logic [63:0]                       pat_hi_r;
  logic [lsf_pkg::LEN_W-1:0]         pat_len_r;
  logic                              case_r;
  logic                              invert_r;
  logic                              nonblank_r;
  logic [lsf_pkg::WIN_W-1:0]         window_r;
  logic [1:0]                        num_mode_r;

  logic             in_acc;
  logic             q_push, q_full, q_pop, q_avail;
  lsf_pkg::entry_t  q_in, q_head;
  logic [31:0]      line_num, shown_num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
      pat_len_r  <= '0;
      case_r     <= 1'b0;
      invert_r   <= 1'b0;
      nonblank_r <= 1'b0;
      window_r   <= '0;
      num_mode_r <= lsf_pkg::NUM_ABSOLUTE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lsf_pkg::REG_PAT_LOW:  pat_lo_r   <= cfg_wdata;
        lsf_pkg::REG_PAT_HIGH: pat_hi_r   <= cfg_wdata;
        lsf_pkg::REG_PAT_LEN:  pat_len_r  <= cfg_wdata[lsf_pkg::LEN_W-1:0];
        lsf_pkg::REG_CASE:     case_r     <= cfg_wdata[0];
        lsf_pkg::REG_INVERT:   invert_r   <= cfg_wdata[0];
        lsf_pkg::REG_NONBLANK: nonblank_r <= cfg_wdata[0];
        lsf_pkg::REG_WINDOW:   window_r   <= cfg_wdata[lsf_pkg::WIN_W-1:0];
        lsf_pkg::REG_NUM_MODE: num_mode_r <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // front accepts whenever the line queue has room; a waiting result stalls it only once full
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  lsf_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .LINE_LIMIT  (LINE_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .action       (lsf_pkg::action_t'(in_tuser)),
    .byte_value   (in_tdata),
    .pat_lo       (pat_lo_r),
    .pat_hi       (pat_hi_r),
    .pat_len      (pat_len_r),
    .exact_case   (case_r),
    .invert       (invert_r),
    .nonblank_ovr (nonblank_r),
    .push         (q_push),
    .push_entry   (q_in)
  );

  // end-of-line and new-file records, in arrival order
  lsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .avail      (q_avail),
    .head       (q_head)
  );

  // line counter, window and numbering, with the output register
  lsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (q_avail),
    .head      (q_head),
    .pop       (q_pop),
    .window    (window_r),
    .num_mode  (num_mode_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sel   (out_tuser),
    .out_line  (line_num),
    .out_shown (shown_num)
  );

  assign out_tdata = {shown_num, line_num};

endmodule

FILE: sv/lsf_front.sv
module lsf_front #(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_LIMIT  = 65530
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  lsf_pkg::action_t            action,
  input  logic [7:0]                  byte_value,
  input  logic [63:0]                 pat_lo,
  input  logic [63:0]                 pat_hi,
  input  logic [lsf_pkg::LEN_W-1:0]   pat_len,
  input  logic                        exact_case,
  input  logic                        invert,
  input  logic                        nonblank_ovr,
  output logic                        push,
  output lsf_pkg::entry_t             push_entry
);

  localparam int HIST = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int LMAX = (PATTERN_MAX < 31) ? PATTERN_MAX : 31;
  localparam logic [lsf_pkg::BIL_W-1:0] BYTE_CAP = lsf_pkg::BIL_W'(LINE_LIMIT - 1);

  logic [7:0]                  hist_r [HIST];
  logic [lsf_pkg::BIL_W-1:0]   bytes_r, bytes_nxt;
  logic                        found_r, found_nxt;
  logic                        nonblank_r, nonblank_nxt;

  logic [lsf_pkg::LEN_W-1:0]   eff_len;
  logic [7:0]                  cur_f [LMAX];
  logic [7:0]                  pat_f [LMAX];
  logic [LMAX:1]               eq;
  logic                        hit;
  logic                        take;
  logic                        found_eol;

  always_comb begin
    if ({2'b00, pat_len} > 7'(PATTERN_MAX)) eff_len = lsf_pkg::LEN_W'(PATTERN_MAX);
    else eff_len = pat_len;
  end

  // folded byte window, newest first, and folded pattern
  always_comb begin
    for (int k = 0; k < LMAX; k++) begin
      if (k == 0) cur_f[k] = lsf_pkg::fold(byte_value, exact_case);
      else cur_f[k] = lsf_pkg::fold(hist_r[k-1], exact_case);
      pat_f[k] = lsf_pkg::fold(lsf_pkg::pat_byte(pat_lo, pat_hi, k), exact_case);
    end
  end

  // one compare row per pattern length
  always_comb begin
    for (int l = 1; l <= LMAX; l++) begin
      eq[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (cur_f[k] != pat_f[l-1-k]) eq[l] = 1'b0;
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= LMAX; l++) begin
      if (eff_len == lsf_pkg::LEN_W'(l) && eq[l]) hit = 1'b1;
    end
    if ({1'b0, bytes_r} + 17'd1 < {12'b0, eff_len}) hit = 1'b0;
  end

  assign take      = acc && action == lsf_pkg::ACT_BYTE && bytes_r < BYTE_CAP;
  assign found_eol = found_r || eff_len == '0;

  always_comb begin
    bytes_nxt    = bytes_r;
    found_nxt    = found_r;
    nonblank_nxt = nonblank_r;
    push         = 1'b0;
    push_entry   = '0;
    if (acc) begin
      case (action)
        lsf_pkg::ACT_BYTE: begin
          if (take) begin
            bytes_nxt = bytes_r + 1'b1;
            if (hit) found_nxt = 1'b1;
            if (bytes_r == '0) nonblank_nxt = byte_value != lsf_pkg::CHR_SPACE;
          end
        end
        lsf_pkg::ACT_EOL: begin
          push = 1'b1;
          push_entry.restart = 1'b0;
          if (nonblank_ovr && bytes_r != '0 && nonblank_r) push_entry.sel = 1'b1;
          else push_entry.sel = invert ^ found_eol;
          bytes_nxt    = '0;
          found_nxt    = 1'b0;
          nonblank_nxt = 1'b0;
        end
        lsf_pkg::ACT_NEW_FILE: begin
          push = 1'b1;
          push_entry.restart = 1'b1;
          bytes_nxt    = '0;
          found_nxt    = 1'b0;
          nonblank_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r    <= '0;
      found_r    <= 1'b0;
      nonblank_r <= 1'b0;
    end else begin
      bytes_r    <= bytes_nxt;
      found_r    <= found_nxt;
      nonblank_r <= nonblank_nxt;
    end
  end

  // byte history, older bytes are never read past the line start
  always_ff @(posedge clk) begin
    if (take) begin
      hist_r[0] <= byte_value;
      for (int i = 1; i < HIST; i++) hist_r[i] <= hist_r[i-1];
    end
  end

endmodule

FILE: sv/lsf_queue.sv
module lsf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lsf_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output lsf_pkg::entry_t head
);

  lsf_pkg::entry_t                mem_r [lsf_pkg::Q_DEPTH];
  logic [lsf_pkg::Q_PTR_W-1:0]    wr_r, rd_r;
  logic [lsf_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                           do_push, do_pop;

  assign full    = cnt_r == lsf_pkg::Q_CNT_W'(lsf_pkg::Q_DEPTH);
  assign avail   = cnt_r != '0;
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_entry;
  end

endmodule

FILE: sv/lsf_back.sv
module lsf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        avail,
  input  lsf_pkg::entry_t             head,
  output logic                        pop,
  input  logic [lsf_pkg::WIN_W-1:0]   window,
  input  logic [1:0]                  num_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_sel,
  output logic [lsf_pkg::CNT_W-1:0]   out_line,
  output logic [lsf_pkg::CNT_W-1:0]   out_shown
);

  localparam int CW = lsf_pkg::CNT_W;

  logic [CW-1:0] lc_r, lc_nxt;
  logic [CW-1:0] lm_r, lm_nxt;
  logic          lmv_r, lmv_nxt;
  logic [CW-1:0] fs_r, fs_nxt;
  logic          fsv_r, fsv_nxt;
  logic          vld_r, vld_nxt;
  logic          sel_r, sel_nxt;
  logic [CW-1:0] line_r, line_nxt;
  logic [CW-1:0] shown_r, shown_nxt;

  logic [CW-1:0] lc_inc;
  logic [CW:0]   win_end;
  logic          in_win;
  logic          sel_f;

  assign pop     = avail && (!vld_r || out_ready);
  assign lc_inc  = lc_r + 1'b1;
  assign win_end = {1'b0, lm_r} + {{(CW + 1 - lsf_pkg::WIN_W){1'b0}}, window};
  assign in_win  = window != '0 && lmv_r && {1'b0, lc_inc} < win_end;
  assign sel_f   = head.sel || in_win;

  always_comb begin
    lc_nxt    = lc_r;
    lm_nxt    = lm_r;
    lmv_nxt   = lmv_r;
    fs_nxt    = fs_r;
    fsv_nxt   = fsv_r;
    vld_nxt   = vld_r && !out_ready;
    sel_nxt   = sel_r;
    line_nxt  = line_r;
    shown_nxt = shown_r;
    if (pop) begin
      if (head.restart) begin
        lc_nxt  = '0;
        lm_nxt  = '0;
        lmv_nxt = 1'b0;
        fs_nxt  = '0;
        fsv_nxt = 1'b0;
      end else begin
        lc_nxt    = lc_inc;
        vld_nxt   = 1'b1;
        sel_nxt   = sel_f;
        line_nxt  = lc_inc;
        shown_nxt = '0;
        if (head.sel && window != '0) begin
          lm_nxt  = lc_inc;
          lmv_nxt = 1'b1;
        end
        if (sel_f) begin
          case (num_mode)
            lsf_pkg::NUM_ABSOLUTE: shown_nxt = lc_inc;
            lsf_pkg::NUM_OFFSET: begin
              if (!fsv_r) begin
                fs_nxt  = lc_inc;
                fsv_nxt = 1'b1;
              end else begin
                shown_nxt = lc_inc - fs_r;
              end
            end
            default: shown_nxt = '0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r  <= '0;
      lm_r  <= '0;
      lmv_r <= 1'b0;
      fs_r  <= '0;
      fsv_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      lc_r  <= lc_nxt;
      lm_r  <= lm_nxt;
      lmv_r <= lmv_nxt;
      fs_r  <= fs_nxt;
      fsv_r <= fsv_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    line_r  <= line_nxt;
    shown_r <= shown_nxt;
  end

  assign out_valid = vld_r;
  assign out_sel   = sel_r;
  assign out_line  = line_r;
  assign out_shown = shown_r;

endmodule
